>>> design/range_merge_table_assert.svh
// Assertion macros for the range merge table checker.
`ifndef RANGE_MERGE_TABLE_ASSERT_SVH
`define RANGE_MERGE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RMT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/rmt_pkg.sv
// Types and constants shared by the range merge table modules.
package rmt_pkg;

    localparam int MAX_RANGES_DEF = 64;
    localparam int ADDR_WIDTH_DEF = 64;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_FIND = 1'b1;

    typedef logic [63:0] t_field;
    typedef logic [6:0]  t_count;

    typedef enum logic [1:0] {
        ST_COVERED = 2'd0,
        ST_ADDED   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NONE    = 2'd3
    } t_add_status;

    typedef struct packed {
        logic   command;
        t_field range_start;
        t_field range_end;
        t_field query_address;
    } t_in;

    typedef struct packed {
        t_add_status add_status;
        logic        hit;
        t_field      found_start;
        t_field      found_end;
        t_count      range_count;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_LO,
        S_MERGE,
        S_KEY,
        S_DECIDE,
        S_COMPACT,
        S_PLACE,
        S_SHIFT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SCAN_FIND,
        OP_SCAN_ADD,
        OP_MERGE,
        OP_KEY,
        OP_COMPACT,
        OP_SHIFT
    } t_op;

    typedef enum logic [2:0] {
        INIT_NONE,
        INIT_MERGE,
        INIT_KEY,
        INIT_COMPACT,
        INIT_SHIFT
    } t_init;

    typedef struct packed {
        logic        load;
        t_init       init;
        t_op         op;
        logic        set_stat;
        t_add_status stat_val;
        logic        shrink;
        logic        put;
        logic        emit;
    } t_dp_cmd;

    typedef struct packed {
        logic pass_done;
        logic covered;
        logic absorbed;
        logic key;
        logic full;
        logic is_find;
    } t_dp_stat;

endpackage

>>> design/rmt_dp.sv
// Datapath: range tables, scan counter, merge and lookup registers, result register.
module rmt_dp #(
    parameter int MAX_RANGES = rmt_pkg::MAX_RANGES_DEF,
    parameter int ADDR_WIDTH = rmt_pkg::ADDR_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rmt_pkg::t_in       i_item,
    input  rmt_pkg::t_dp_cmd   i_cmd,
    output rmt_pkg::t_dp_stat  o_stat,
    output rmt_pkg::t_out      o_item
);
    import rmt_pkg::*;

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = AW + 1;

    typedef logic [ADDR_WIDTH-1:0] t_addr;

    t_addr start_mem [MAX_RANGES];
    t_addr end_mem   [MAX_RANGES];

    logic [CW-1:0] r_cnt, r_k, r_lim, r_lo, r_hi, r_pos;
    logic          r_pv, r_find, r_ubv, r_fv, r_stop, r_key;
    logic [AW-1:0] r_pidx;
    t_addr         r_s, r_e, r_a, r_rd_start, r_rd_end, r_ub_end, r_lm1_end;
    t_addr         r_fs, r_fe, r_ns, r_ne;
    t_add_status   r_stat;
    t_out          r_out;

    logic [CW-1:0] lo_adj, gap, rd_addr;
    logic          active, outside, hit;
    logic          we, we_start;
    logic [AW-1:0] waddr;
    t_addr         wstart, wend;

    always_comb begin
        lo_adj  = (r_lo != '0 && r_lm1_end >= r_s) ? r_lo - 1'b1 : r_lo;
        gap     = r_hi - r_lo;
        active  = (i_cmd.op != OP_NONE) && (r_k < r_lim) && !(i_cmd.op == OP_MERGE && r_stop);
        rd_addr = (i_cmd.op == OP_SHIFT) ? r_cnt - 1'b1 - r_k : r_k;
        outside = ({1'b0, r_pidx} < r_lo) || ({1'b0, r_pidx} >= r_hi);
        hit     = r_find && r_fv && (r_a < r_fe);
    end

    always_comb begin
        we       = 1'b0;
        we_start = 1'b1;
        waddr    = r_pidx;
        wstart   = r_rd_start;
        wend     = r_rd_end;
        if (i_cmd.put) begin
            we       = 1'b1;
            we_start = !r_key;
            waddr    = r_pos[AW-1:0];
            wstart   = r_ns;
            wend     = r_ne;
        end else if (r_pv && i_cmd.op == OP_COMPACT) begin
            we    = 1'b1;
            waddr = r_pidx - gap[AW-1:0];
        end else if (r_pv && i_cmd.op == OP_SHIFT) begin
            we    = 1'b1;
            waddr = r_pidx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            if (we_start) begin
                start_mem[waddr] <= wstart;
            end
            end_mem[waddr] <= wend;
        end
        r_rd_start <= start_mem[rd_addr[AW-1:0]];
        r_rd_end   <= end_mem[rd_addr[AW-1:0]];
        r_pidx     <= rd_addr[AW-1:0];
    end

    // scan counter and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_k   <= '0;
            r_lim <= '0;
            r_pv  <= 1'b0;
        end else begin
            r_pv <= active;
            if (active) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.load) begin
                r_k   <= '0;
                r_lim <= r_cnt;
            end
            unique case (i_cmd.init)
                INIT_MERGE: begin
                    r_k   <= lo_adj;
                    r_lim <= r_cnt;
                end
                INIT_KEY: begin
                    r_k   <= '0;
                    r_lim <= r_cnt;
                end
                INIT_COMPACT: begin
                    r_k   <= r_hi;
                    r_lim <= r_cnt;
                end
                INIT_SHIFT: begin
                    r_k   <= '0;
                    r_lim <= r_cnt - r_pos;
                end
                INIT_NONE: ;
                default: ;
            endcase
            if (i_cmd.shrink) begin
                r_cnt <= r_cnt - gap;
            end
            if (i_cmd.put && !r_key) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_find <= i_item.command;
            r_s    <= i_item.range_start[ADDR_WIDTH-1:0];
            r_e    <= i_item.range_end[ADDR_WIDTH-1:0];
            r_a    <= i_item.query_address[ADDR_WIDTH-1:0];
            r_stat <= (i_item.command == CMD_FIND) ? ST_NONE : ST_ADDED;
            r_ubv  <= 1'b0;
            r_fv   <= 1'b0;
            r_lo   <= '0;
        end
        if (i_cmd.set_stat) begin
            r_stat <= i_cmd.stat_val;
        end
        if (i_cmd.init == INIT_MERGE) begin
            r_lo   <= lo_adj;
            r_hi   <= lo_adj;
            r_ns   <= r_s;
            r_ne   <= r_e;
            r_stop <= 1'b0;
        end
        if (i_cmd.init == INIT_KEY) begin
            r_pos <= '0;
            r_key <= 1'b0;
        end
        if (r_pv) begin
            unique case (i_cmd.op)
                OP_SCAN_FIND: begin
                    if (r_rd_start <= r_a) begin
                        r_fv <= 1'b1;
                        r_fs <= r_rd_start;
                        r_fe <= r_rd_end;
                    end
                end
                OP_SCAN_ADD: begin
                    if (r_rd_start < r_s) begin
                        r_lo      <= {1'b0, r_pidx} + 1'b1;
                        r_lm1_end <= r_rd_end;
                    end
                    if (r_rd_start <= r_s) begin
                        r_ubv    <= 1'b1;
                        r_ub_end <= r_rd_end;
                    end
                end
                OP_MERGE: begin
                    if (!r_stop) begin
                        if (r_rd_start <= r_ne) begin
                            r_ns <= (r_rd_start < r_ns) ? r_rd_start : r_ns;
                            r_ne <= (r_rd_end > r_ne) ? r_rd_end : r_ne;
                            r_hi <= {1'b0, r_pidx} + 1'b1;
                        end else begin
                            r_stop <= 1'b1;
                        end
                    end
                end
                OP_KEY: begin
                    if (outside && r_rd_start < r_ns) begin
                        r_pos <= r_pos + 1'b1;
                    end
                    if (outside && r_rd_start == r_ns) begin
                        r_key <= 1'b1;
                    end
                end
                OP_NONE, OP_COMPACT, OP_SHIFT: ;
                default: ;
            endcase
        end
        if (i_cmd.emit) begin
            r_out.add_status  <= r_stat;
            r_out.hit         <= hit;
            r_out.found_start <= hit ? t_field'(r_fs) : '0;
            r_out.found_end   <= hit ? t_field'(r_fe) : '0;
            r_out.range_count <= t_count'(r_cnt);
        end
    end

    always_comb begin
        o_stat.pass_done = !active && !r_pv;
        o_stat.covered   = r_ubv && (r_e <= r_ub_end);
        o_stat.absorbed  = (r_hi != r_lo);
        o_stat.key       = r_key;
        o_stat.full      = (r_cnt == CW'(MAX_RANGES));
        o_stat.is_find   = r_find;
    end

    assign o_item = r_out;

endmodule

>>> design/rmt_ctrl.sv
// Controller: sequences the scan, merge, compaction and insertion passes.
module rmt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  rmt_pkg::t_dp_stat i_stat,
    output rmt_pkg::t_dp_cmd  o_cmd
);
    import rmt_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.pass_done) n_state = i_stat.is_find ? S_OUT : S_LO;
            end
            S_LO: begin
                n_state = i_stat.covered ? S_OUT : S_MERGE;
            end
            S_MERGE: begin
                if (i_stat.pass_done) n_state = S_KEY;
            end
            S_KEY: begin
                if (i_stat.pass_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                priority if (!i_stat.absorbed && !i_stat.key && i_stat.full) n_state = S_OUT;
                else if (i_stat.absorbed) n_state = S_COMPACT;
                else n_state = S_PLACE;
            end
            S_COMPACT: begin
                if (i_stat.pass_done) n_state = S_PLACE;
            end
            S_PLACE: begin
                priority if (i_stat.key) n_state = S_OUT;
                else if (!i_stat.full) n_state = S_SHIFT;
                else n_state = S_OUT;
            end
            S_SHIFT: begin
                if (i_stat.pass_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        n_ovalid = r_ovalid && !i_ready;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_valid;
            end
            S_SCAN: begin
                o_cmd.op = i_stat.is_find ? OP_SCAN_FIND : OP_SCAN_ADD;
            end
            S_LO: begin
                if (i_stat.covered) begin
                    o_cmd.set_stat = 1'b1;
                    o_cmd.stat_val = ST_COVERED;
                end else begin
                    o_cmd.init = INIT_MERGE;
                end
            end
            S_MERGE: begin
                o_cmd.op = OP_MERGE;
                if (i_stat.pass_done) o_cmd.init = INIT_KEY;
            end
            S_KEY: begin
                o_cmd.op = OP_KEY;
            end
            S_DECIDE: begin
                priority if (!i_stat.absorbed && !i_stat.key && i_stat.full) begin
                    o_cmd.set_stat = 1'b1;
                    o_cmd.stat_val = ST_FULL;
                end else if (i_stat.absorbed) begin
                    o_cmd.init = INIT_COMPACT;
                end else begin
                    o_cmd.init = INIT_NONE;
                end
            end
            S_COMPACT: begin
                o_cmd.op     = OP_COMPACT;
                o_cmd.shrink = i_stat.pass_done;
            end
            S_PLACE: begin
                priority if (i_stat.key) o_cmd.put = 1'b1;
                else if (!i_stat.full) o_cmd.init = INIT_SHIFT;
                else o_cmd.init = INIT_NONE;
            end
            S_SHIFT: begin
                o_cmd.op  = OP_SHIFT;
                o_cmd.put = i_stat.pass_done;
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    o_cmd.emit = 1'b1;
                    n_ovalid   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

endmodule

>>> design/range_merge_table.sv
// Top level of the range merge table.
// Sorted table of disjoint half-open ranges [start, end) with add and find commands.
// Input channel: i_valid / o_ready carry i_item (command, range_start, range_end,
// query_address). Output channel: o_valid / i_ready carry o_item (add_status, hit,
// found_start, found_end, range_count), exactly one result item per input item.
// One item is worked on at a time; o_ready is high only when the controller is idle.
// Each command scans the table through one memory read port, one entry per cycle.
// A find runs one lookup scan over the N entries, N being the entry count.
// An add runs at most a lookup scan, a merge scan, a scan for the insert position, then a
// compaction pass and an insertion shift that each move at most N entries through
// the single read and single write port.
// A finished result sits in the output register; the next item is accepted while it waits,
// and only the hand-over of the following result stalls on i_ready.
// Reset empties the table (entry count zero) and drops any pending result; no clearing
// pass runs, since only entries below the count are ever read.
module range_merge_table #(
    parameter int MAX_RANGES = rmt_pkg::MAX_RANGES_DEF,
    parameter int ADDR_WIDTH = rmt_pkg::ADDR_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rmt_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output rmt_pkg::t_out o_item
);
    import rmt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rmt_dp #(
        .MAX_RANGES (MAX_RANGES),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_item  (o_item)
    );

endmodule

>>> design/rmt_checker.sv
// Port-level checker for the range merge table, bound to the top level.
`include "range_merge_table_assert.svh"

module rmt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input rmt_pkg::t_out o_item
);
    import rmt_pkg::*;

    `RMT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_item), "result item changed while stalled")

    `RMT_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "second item taken while one is at work")

    `RMT_ASSERT_NOW(a_add_no_hit, i_clk, i_rst_n, o_valid && o_item.add_status != ST_NONE, !o_item.hit && o_item.found_start == '0 && o_item.found_end == '0, "add result carries lookup data")

    `RMT_ASSERT_NOW(a_hit_range, i_clk, i_rst_n, o_valid && o_item.hit, o_item.found_start < o_item.found_end, "hit on an empty range")

endmodule

bind range_merge_table rmt_checker u_rmt_checker (.*);
